/* hw/rtl/ipl_pkg.sv */
// shared constants and types for the identity pattern labeler
package ipl_pkg;

    // longest vector that is labeled; later elements of a vector are ignored
    localparam int MAX_GENES = 16;

    localparam int GENE_W  = 16;
    localparam int LABEL_W = 48;
    localparam int COUNT_W = 5;
    localparam int POS_W   = $clog2(MAX_GENES + 1);
    localparam int IDX_W   = $clog2(MAX_GENES);

    typedef logic [GENE_W-1:0] t_gene;

    // result of the lookup of one value among the classes opened so far
    typedef struct packed {
        logic [MAX_GENES-1:0] hit_vec;
        logic                 hit;
        logic [IDX_W-1:0]     idx;
    } t_match;

endpackage

/* hw/rtl/ipl_match.sv */
// parallel compare of a gene value against the stored class values
module ipl_match (
    input  ipl_pkg::t_gene              i_seen [ipl_pkg::MAX_GENES],
    input  logic [ipl_pkg::POS_W-1:0]   i_class_total,
    input  ipl_pkg::t_gene              i_value,
    output ipl_pkg::t_match             o_match
);

    logic [ipl_pkg::MAX_GENES-1:0] w_hit_vec;

    // only entries below the class count hold a written value
    always_comb begin
        for (int c = 0; c < ipl_pkg::MAX_GENES; c++) begin
            w_hit_vec[c] = (ipl_pkg::POS_W'(c) < i_class_total) && (i_seen[c] == i_value);
        end
    end

    // lowest matching class wins
    always_comb begin
        o_match.hit_vec = w_hit_vec;
        o_match.hit     = |w_hit_vec;
        o_match.idx     = '0;
        for (int c = ipl_pkg::MAX_GENES - 1; c >= 0; c--) begin
            if (w_hit_vec[c]) begin
                o_match.idx = ipl_pkg::IDX_W'(c);
            end
        end
    end

endmodule

/* hw/rtl/identity_pattern_labeler_unit.sv */
// top level of the identity pattern labeler: input register, class update, result register
// throughput: one element per cycle unless o_in_stall is raised; a last element's result
//   is registered in the result register; class lookup, label multiply-add and state update
//   sit in one stage between the input register and the vector state / result registers
// a last element waits in the input register only while the result register holds a
//   result not yet taken; reset (synchronous, active low) empties both registers and
//   clears the vector state, the stored class values are not cleared
module identity_pattern_labeler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // element channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ipl_pkg::GENE_W-1:0]    i_gene_value,
    input  logic                          i_last_gene,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ipl_pkg::LABEL_W-1:0]   o_pattern_label,
    output logic [ipl_pkg::COUNT_W-1:0]   o_distinct_count
);

    // input register
    logic                         r_in_valid;
    ipl_pkg::t_gene               r_in_value;
    logic                         r_in_last;

    // vector state
    ipl_pkg::t_gene               r_seen [ipl_pkg::MAX_GENES];
    logic [ipl_pkg::POS_W-1:0]    r_class_total;
    logic [ipl_pkg::POS_W-1:0]    r_position;
    logic [ipl_pkg::LABEL_W-1:0]  r_label;

    // result register
    logic                         r_out_valid;
    logic [ipl_pkg::LABEL_W-1:0]  r_out_label;
    logic [ipl_pkg::POS_W-1:0]    r_out_count;

    logic [ipl_pkg::POS_W-1:0]    n_class_total;
    logic [ipl_pkg::POS_W-1:0]    n_position;
    logic [ipl_pkg::LABEL_W-1:0]  n_label;

    ipl_pkg::t_match              w_match;
    logic                         w_fire;
    logic                         w_in_take;
    logic                         w_out_take;
    logic                         w_room;
    logic                         w_update;
    logic                         w_new_class;
    logic [ipl_pkg::IDX_W-1:0]    w_cls_m1;
    logic [ipl_pkg::LABEL_W-1:0]  w_prod;

    // --- handshake ---------------------------------------------------------

    assign w_out_take = r_out_valid && !i_out_stall;
    // a non-last element never needs the result register
    assign w_fire     = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // --- class lookup and label update -------------------------------------

    ipl_match u_match (
        .i_seen        (r_seen),
        .i_class_total (r_class_total),
        .i_value       (r_in_value),
        .o_match       (w_match)
    );

    // elements past the vector limit leave the state alone
    assign w_room      = r_position < ipl_pkg::POS_W'(ipl_pkg::MAX_GENES);
    assign w_update    = w_fire && w_room;
    assign w_new_class = !w_match.hit;

    // class minus one: the matched class, or the class about to open;
    // the class count stays below the limit here since it never passes the position
    assign w_cls_m1 = w_match.hit ? w_match.idx : r_class_total[ipl_pkg::IDX_W-1:0];

    // position * label, kept modulo 2^48
    assign w_prod = r_label * ipl_pkg::LABEL_W'(r_position);

    always_comb begin
        n_class_total = r_class_total;
        n_position    = r_position;
        n_label       = r_label;
        if (w_update) begin
            n_class_total = r_class_total + ipl_pkg::POS_W'(w_new_class);
            n_position    = r_position + ipl_pkg::POS_W'(1);
            n_label       = w_prod + ipl_pkg::LABEL_W'(w_cls_m1);
        end
        // the last element closes the vector
        if (w_fire && r_in_last) begin
            n_class_total = '0;
            n_position    = '0;
            n_label       = '0;
        end
    end

    // --- registers ---------------------------------------------------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_value <= i_gene_value;
            r_in_last  <= i_last_gene;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_total <= '0;
            r_position    <= '0;
            r_label       <= '0;
        end else begin
            r_class_total <= n_class_total;
            r_position    <= n_position;
            r_label       <= n_label;
        end
    end

    // a new class stores its value at the next free entry
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < ipl_pkg::MAX_GENES; c++) begin
            if (w_update && w_new_class
                    && (r_class_total[ipl_pkg::IDX_W-1:0] == ipl_pkg::IDX_W'(c))) begin
                r_seen[c] <= r_in_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // the result carries the state after this element's own update
    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out_label <= w_update ? (w_prod + ipl_pkg::LABEL_W'(w_cls_m1)) : r_label;
            r_out_count <= w_update ? (r_class_total + ipl_pkg::POS_W'(w_new_class))
                                    : r_class_total;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pattern_label  = r_out_label;
    assign o_distinct_count = ipl_pkg::COUNT_W'(r_out_count);

    // --- assertions --------------------------------------------------------

    // a vector never holds more classes than elements
    a_class_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_class_total <= r_position)
        else $error("class count exceeds position");

    // position stops at the vector limit
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= ipl_pkg::POS_W'(ipl_pkg::MAX_GENES))
        else $error("position past vector limit");

    // stored class values are distinct, so at most one can match
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match.hit_vec))
        else $error("value matches more than one class");

    // a closed vector leaves clean state behind
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_last |=> r_position == '0 && r_class_total == '0 && r_label == '0)
        else $error("vector state not cleared after last element");

    // every result counts at least one class
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_count != '0)
        else $error("result with zero distinct count");

endmodule
